// File: rtl/sat_pkg.sv
// shared constants and types for the segment versus box overlap pipeline
package sat_pkg;

   // width of every coordinate field on the request channel
   localparam int FIELD_BITS = 32;

   // default number of coordinate bits taken from each field
   localparam int COORD_BITS_DEF = 32;

   // slack register
   localparam int EPS_BITS = 16;
   localparam logic [EPS_BITS-1:0] PARALLEL_EPSILON_RESET = 16'd16;

   // number of world axes
   localparam int AXES = 3;

   // load enables handed to a cross-axis unit
   typedef struct packed {
      logic prod;
      logic diff;
   } cross_en_type;

endpackage

// File: rtl/sat_if.sv
// request and response channel interfaces of the overlap pipeline

interface sat_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [sat_pkg::FIELD_BITS-1:0] seg_start_x;
   logic signed [sat_pkg::FIELD_BITS-1:0] seg_start_y;
   logic signed [sat_pkg::FIELD_BITS-1:0] seg_start_z;
   logic signed [sat_pkg::FIELD_BITS-1:0] seg_end_x;
   logic signed [sat_pkg::FIELD_BITS-1:0] seg_end_y;
   logic signed [sat_pkg::FIELD_BITS-1:0] seg_end_z;
   logic signed [sat_pkg::FIELD_BITS-1:0] box_min_x;
   logic signed [sat_pkg::FIELD_BITS-1:0] box_min_y;
   logic signed [sat_pkg::FIELD_BITS-1:0] box_min_z;
   logic signed [sat_pkg::FIELD_BITS-1:0] box_max_x;
   logic signed [sat_pkg::FIELD_BITS-1:0] box_max_y;
   logic signed [sat_pkg::FIELD_BITS-1:0] box_max_z;

   modport source (
      output valid, seg_start_x, seg_start_y, seg_start_z,
             seg_end_x, seg_end_y, seg_end_z,
             box_min_x, box_min_y, box_min_z,
             box_max_x, box_max_y, box_max_z,
      input  ready
   );

   modport sink (
      input  valid, seg_start_x, seg_start_y, seg_start_z,
             seg_end_x, seg_end_y, seg_end_z,
             box_min_x, box_min_y, box_min_z,
             box_max_x, box_max_y, box_max_z,
      output ready
   );
endinterface

interface sat_rsp_if;
   logic valid;
   logic ready;
   logic overlaps;

   modport source (output valid, overlaps, input ready);
   modport sink (input valid, overlaps, output ready);
endinterface

// File: rtl/sat_cross.sv
// one cross-axis separation test: product stage, then difference and sum stage
module sat_cross #(
   parameter int COORD_BITS = sat_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  sat_pkg::cross_en_type        en,
   input  logic signed [COORD_BITS+1:0] ma,
   input  logic signed [COORD_BITS:0]   db,
   input  logic signed [COORD_BITS+1:0] mb,
   input  logic signed [COORD_BITS:0]   da,
   input  logic signed [COORD_BITS:0]   ea,
   input  logic signed [COORD_BITS+2:0] adb,
   input  logic signed [COORD_BITS:0]   eb,
   input  logic signed [COORD_BITS+2:0] ada,
   output logic                         sep
);

   localparam int MW  = COORD_BITS + 2;
   localparam int DW  = COORD_BITS + 1;
   localparam int AW  = COORD_BITS + 3;
   localparam int PMW = MW + DW;
   localparam int PEW = DW + AW;
   localparam int CW  = PEW + 1;

   logic signed [PMW-1:0] p_ma_db_ff;
   logic signed [PMW-1:0] p_mb_da_ff;
   logic signed [PEW-1:0] p_ea_adb_ff;
   logic signed [PEW-1:0] p_eb_ada_ff;
   logic signed [CW-1:0]  diff_ff;
   logic signed [CW-1:0]  rhs_ff;
   logic signed [CW-1:0]  diff_in;
   logic signed [CW-1:0]  rhs_in;
   logic signed [CW-1:0]  neg_sum;

   // full-width products
   always_ff @(posedge clock) begin
      if (en.prod) begin
         p_ma_db_ff  <= PMW'(ma) * PMW'(db);
         p_mb_da_ff  <= PMW'(mb) * PMW'(da);
         p_ea_adb_ff <= PEW'(ea) * PEW'(adb);
         p_eb_ada_ff <= PEW'(eb) * PEW'(ada);
      end
   end

   // projected center distance and projected radius
   assign diff_in = CW'(p_ma_db_ff) - CW'(p_mb_da_ff);
   assign rhs_in  = CW'(p_ea_adb_ff) + CW'(p_eb_ada_ff);

   always_ff @(posedge clock) begin
      if (en.diff) begin
         diff_ff <= diff_in;
         rhs_ff  <= rhs_in;
      end
   end

   // |diff| > rhs, both signs tested in parallel (-diff > rhs means diff + rhs < 0)
   assign neg_sum = diff_ff + rhs_ff;
   assign sep     = (diff_ff > rhs_ff) || neg_sum[CW-1];

endmodule

// File: rtl/segment_aabb_overlap_test.sv
// segment versus axis-aligned box separating axis test, top level
// throughput: one beat per cycle; stages hold only while all later ones are full and stalled
// five register stages: differences, axis tests, products, sums, response register
// reset clears all stage valid bits and sets the slack register to 16
module segment_aabb_overlap_test #(
   parameter int COORD_BITS = sat_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [sat_pkg::EPS_BITS-1:0]  csr_wdata,
   sat_req_if.sink                       req_if,
   sat_rsp_if.source                     rsp_if
);

   localparam int FB  = sat_pkg::FIELD_BITS;
   localparam int NA  = sat_pkg::AXES;
   localparam int EB  = sat_pkg::EPS_BITS;
   localparam int XW  = (COORD_BITS > FB) ? COORD_BITS : FB;
   localparam int MW  = COORD_BITS + 2;
   localparam int DW  = COORD_BITS + 1;
   localparam int AW  = COORD_BITS + 3;
   localparam int AXW = COORD_BITS + 4;

   // slack register
   logic [EB-1:0] slack_ff;

   // stage valid bits and ready chain
   logic v1_ff, v2_ff, v3_ff, v4_ff, ov_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // request fields and their coordinates
   logic signed [FB-1:0]         raw [4*NA];
   logic signed [COORD_BITS-1:0] crd [4*NA];

   // stage 1
   logic signed [MW-1:0] m_in [NA];
   logic signed [DW-1:0] d_in [NA];
   logic signed [DW-1:0] e_in [NA];
   logic signed [MW-1:0] m1_ff [NA];
   logic signed [DW-1:0] d1_ff [NA];
   logic signed [DW-1:0] e1_ff [NA];

   // stage 2
   logic [MW-1:0]         abs_m [NA];
   logic [DW-1:0]         abs_d [NA];
   logic signed [AXW-1:0] ax_lhs [NA];
   logic signed [AXW-1:0] ax_rhs [NA];
   logic [NA-1:0]         axsep_in;
   logic signed [AW-1:0]  adp_in [NA];
   logic signed [MW-1:0]  m2_ff [NA];
   logic signed [DW-1:0]  d2_ff [NA];
   logic signed [DW-1:0]  e2_ff [NA];
   logic signed [AW-1:0]  adp2_ff [NA];
   logic                  axsep2_ff;

   // stages 3 and 4 and response
   logic                  axsep3_ff;
   logic                  axsep4_ff;
   logic [NA-1:0]         xsep;
   sat_pkg::cross_en_type cen;
   logic                  overlaps_ff;

   // slack register write
   always_ff @(posedge clock) begin
      if (reset) begin
         slack_ff <= sat_pkg::PARALLEL_EPSILON_RESET;
      end else if (csr_we) begin
         slack_ff <= csr_wdata;
      end
   end

   // ready chain: a stage takes a beat when empty or when it drains this cycle
   assign rdy5 = !ov_ff || rsp_if.ready;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_if.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_if.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) ov_ff <= v4_ff;
      end
   end

   // gather fields: start, end, min, max, each x y z
   assign raw[0]  = req_if.seg_start_x;
   assign raw[1]  = req_if.seg_start_y;
   assign raw[2]  = req_if.seg_start_z;
   assign raw[3]  = req_if.seg_end_x;
   assign raw[4]  = req_if.seg_end_y;
   assign raw[5]  = req_if.seg_end_z;
   assign raw[6]  = req_if.box_min_x;
   assign raw[7]  = req_if.box_min_y;
   assign raw[8]  = req_if.box_min_z;
   assign raw[9]  = req_if.box_max_x;
   assign raw[10] = req_if.box_max_y;
   assign raw[11] = req_if.box_max_z;

   // take the low coordinate bits, sign-extended
   for (genvar i = 0; i < 4*NA; i++) begin : g_crd
      logic signed [XW-1:0] ext;
      assign ext    = XW'(raw[i]);
      assign crd[i] = ext[COORD_BITS-1:0];
   end

   // stage 1: doubled midpoint offset, doubled direction, doubled extent
   always_comb begin
      for (int k = 0; k < NA; k++) begin
         m_in[k] = (MW'(crd[k]) + MW'(crd[NA+k])) - (MW'(crd[2*NA+k]) + MW'(crd[3*NA+k]));
         d_in[k] = DW'(crd[NA+k]) - DW'(crd[k]);
         e_in[k] = DW'(crd[3*NA+k]) - DW'(crd[2*NA+k]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         m1_ff <= m_in;
         d1_ff <= d_in;
         e1_ff <= e_in;
      end
   end

   // stage 2: world axis tests and slack-padded absolute direction
   always_comb begin
      for (int k = 0; k < NA; k++) begin
         abs_m[k]    = (m1_ff[k] < 0) ? MW'(-m1_ff[k]) : MW'(m1_ff[k]);
         abs_d[k]    = (d1_ff[k] < 0) ? DW'(-d1_ff[k]) : DW'(d1_ff[k]);
         ax_lhs[k]   = AXW'($signed({1'b0, abs_m[k]}));
         ax_rhs[k]   = AXW'(e1_ff[k]) + AXW'($signed({1'b0, abs_d[k]}));
         axsep_in[k] = ax_lhs[k] > ax_rhs[k];
         adp_in[k]   = AW'($signed({1'b0, abs_d[k]})) + AW'($signed({1'b0, slack_ff, 1'b0}));
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         m2_ff     <= m1_ff;
         d2_ff     <= d1_ff;
         e2_ff     <= e1_ff;
         adp2_ff   <= adp_in;
         axsep2_ff <= |axsep_in;
      end
   end

   // stages 3 and 4: cross-axis tests
   assign cen.prod = rdy3;
   assign cen.diff = rdy4;

   // direction cross x axis
   sat_cross #(.COORD_BITS(COORD_BITS)) u_cross_x (
      .clock (clock),
      .en    (cen),
      .ma    (m2_ff[1]),
      .db    (d2_ff[2]),
      .mb    (m2_ff[2]),
      .da    (d2_ff[1]),
      .ea    (e2_ff[1]),
      .adb   (adp2_ff[2]),
      .eb    (e2_ff[2]),
      .ada   (adp2_ff[1]),
      .sep   (xsep[0])
   );

   // direction cross y axis
   sat_cross #(.COORD_BITS(COORD_BITS)) u_cross_y (
      .clock (clock),
      .en    (cen),
      .ma    (m2_ff[2]),
      .db    (d2_ff[0]),
      .mb    (m2_ff[0]),
      .da    (d2_ff[2]),
      .ea    (e2_ff[0]),
      .adb   (adp2_ff[2]),
      .eb    (e2_ff[2]),
      .ada   (adp2_ff[0]),
      .sep   (xsep[1])
   );

   // direction cross z axis
   sat_cross #(.COORD_BITS(COORD_BITS)) u_cross_z (
      .clock (clock),
      .en    (cen),
      .ma    (m2_ff[0]),
      .db    (d2_ff[1]),
      .mb    (m2_ff[1]),
      .da    (d2_ff[0]),
      .ea    (e2_ff[0]),
      .adb   (adp2_ff[1]),
      .eb    (e2_ff[1]),
      .ada   (adp2_ff[0]),
      .sep   (xsep[2])
   );

   // world axis flag rides along the cross stages
   always_ff @(posedge clock) begin
      if (rdy3) axsep3_ff <= axsep2_ff;
      if (rdy4) axsep4_ff <= axsep3_ff;
   end

   // response register
   always_ff @(posedge clock) begin
      if (rdy5) begin
         overlaps_ff <= !(axsep4_ff || (|xsep));
      end
   end

   assign rsp_if.valid    = ov_ff;
   assign rsp_if.overlaps = overlaps_ff;

   // a beat moving out of stage 1 always lands in stage 2
   a_stage2_fill: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && rdy2) |=> v2_ff)
      else $error("beat lost between stage 1 and stage 2");

   // a stalled beat in stage 4 is neither dropped nor moved
   a_stage4_hold: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !rdy4) |=> (v4_ff && $stable(axsep4_ff)))
      else $error("stalled beat in stage 4 changed");

   // a separating world axis always yields a miss
   a_axis_miss: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && rdy5 && axsep4_ff) |=> (ov_ff && !overlaps_ff))
      else $error("world axis separation reported as overlap");

endmodule
